### src/glb_container_validator_macros.svh
// Assertion macros for the GLB container validator.
// Taken in by `include in the modules that check their own logic.
`ifndef GLB_CONTAINER_VALIDATOR_MACROS_SVH
`define GLB_CONTAINER_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define GCV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glb_container_validator: check failed");
// Next-cycle implication, checked out of reset.
`define GCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glb_container_validator: check failed");
`else
`define GCV_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GCV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/gcv_pkg.sv
// Constants and types for the GLB container validator.
// No dependencies; used by glb_container_validator.
package gcv_pkg;

  localparam logic [31:0] GLB_MAGIC          = 32'h4654_6c67;
  localparam logic [31:0] TYPE_JSON          = 32'h4e4f_534a;
  localparam logic [31:0] TYPE_BIN           = 32'h004e_4942;
  localparam logic [31:0] GLB_VERSION        = 32'd2;
  localparam int unsigned MIN_GLB_SIZE       = 20;
  localparam int unsigned FILE_HEADER_BYTES  = 12;
  localparam int unsigned CHUNK_HEADER_BYTES = 8;
  localparam int unsigned MAGIC_BYTES        = 4;
  localparam int unsigned VERSION_END        = 8;

  // Register map
  localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_INVALID  = 2'd2,
    STATUS_VERSION  = 2'd3
  } status_t;

endpackage

### src/glb_container_validator.sv
// GLB container validator: byte-stream framing check with one verdict per file.
// Depends on gcv_pkg and glb_container_validator_macros.svh.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s_      | in  | tvalid/tready     | tdata: data_byte; tlast: last_byte
//  m_      | out | tvalid/tready     | tdata: status, is_binary, offset, length
//  apb     | in  | psel/penable      | max_length at byte address 0
//
// One byte is taken per cycle unless a held verdict stalls the input; the verdict
// for the last byte of a file is registered and shows on m_ the cycle after it is taken.
// The byte counter, header words and chunk walker update in the accept cycle.
// A held verdict blocks input only when m_tready is low and m_tvalid is set.
// Reset (rst, synchronous) clears the file state and sets max_length to all ones.

`include "glb_container_validator_macros.svh"

module glb_container_validator #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [1:0] status, [2] is_binary, [34:3] json_offset,
                                 // [66:35] json_length, [71:67] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [31:0]            max_length;
  logic [LENGTH_BITS-1:0] byte_position, byte_position_next;
  logic                   too_long, too_long_next;
  logic [31:0]            magic_word, magic_word_next;
  logic [31:0]            version_word, version_word_next;
  logic [31:0]            declared_length, declared_length_next;
  logic                   in_payload, in_payload_next;
  logic [2:0]             header_byte_index, header_byte_index_next;
  logic [31:0]            chunk_size_word, chunk_size_word_next;
  logic [31:0]            chunk_type_word, chunk_type_word_next;
  logic [31:0]            payload_left, payload_left_next;
  logic [1:0]             chunk_number, chunk_number_next;
  logic                   saw_binary_chunk, saw_binary_chunk_next;
  logic                   chunk_fault, chunk_fault_next;
  logic [LENGTH_BITS-1:0] json_start, json_start_next;
  logic [31:0]            json_size, json_size_next;

  gcv_pkg::status_t       out_status, verdict_status;
  logic                   out_binary, verdict_binary;
  logic [31:0]            out_offset, verdict_offset;
  logic [31:0]            out_length, verdict_length;

  logic                   in_accept;
  logic                   cfg_write;
  logic [LENGTH_BITS-1:0] cursor;
  logic [31:0]            cursor_wide;
  logic [31:0]            room;
  logic [31:0]            hdr_type;
  logic                   hdr_fault;
  logic [31:0]            count_wide;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == gcv_pkg::REG_MAX_LENGTH) ? max_length : 32'd0;

  assign cursor      = byte_position + LENGTH_BITS'(1);
  assign cursor_wide = 32'(cursor);
  assign room        = (declared_length > cursor_wide) ? (declared_length - cursor_wide) : 32'd0;
  // Type word as it stands once the eighth header byte is shifted in
  assign hdr_type    = {s_tdata, chunk_type_word[31:8]};

  // Per-byte state update
  always_comb begin
    byte_position_next     = byte_position;
    too_long_next          = too_long;
    magic_word_next        = magic_word;
    version_word_next      = version_word;
    declared_length_next   = declared_length;
    in_payload_next        = in_payload;
    header_byte_index_next = header_byte_index;
    chunk_size_word_next   = chunk_size_word;
    chunk_type_word_next   = chunk_type_word;
    payload_left_next      = payload_left;
    chunk_number_next      = chunk_number;
    saw_binary_chunk_next  = saw_binary_chunk;
    chunk_fault_next       = chunk_fault;
    json_start_next        = json_start;
    json_size_next         = json_size;
    hdr_fault              = 1'b0;

    if (byte_position == COUNT_MAX) begin
      too_long_next = 1'b1;
    end else begin
      if (byte_position < LENGTH_BITS'(gcv_pkg::MAGIC_BYTES)) begin
        magic_word_next = {s_tdata, magic_word[31:8]};
      end else if (byte_position < LENGTH_BITS'(gcv_pkg::VERSION_END)) begin
        version_word_next = {s_tdata, version_word[31:8]};
      end else if (byte_position < LENGTH_BITS'(gcv_pkg::FILE_HEADER_BYTES)) begin
        declared_length_next = {s_tdata, declared_length[31:8]};
      end else if (!chunk_fault) begin
        if (in_payload) begin
          payload_left_next = payload_left - 32'd1;
          if (payload_left == 32'd1) begin
            in_payload_next = 1'b0;
          end
        end else begin
          if (!header_byte_index[2]) begin
            chunk_size_word_next = {s_tdata, chunk_size_word[31:8]};
          end else begin
            chunk_type_word_next = hdr_type;
          end
          if (header_byte_index == 3'(gcv_pkg::CHUNK_HEADER_BYTES - 1)) begin
            header_byte_index_next = '0;
            // Close the chunk header: size and placement rules
            if (chunk_size_word[1:0] != 2'b00 || chunk_size_word > room) begin
              hdr_fault = 1'b1;
            end else if (chunk_number == 2'd0) begin
              if (hdr_type != gcv_pkg::TYPE_JSON || chunk_size_word == 32'd0) begin
                hdr_fault = 1'b1;
              end else begin
                json_start_next = cursor;
                json_size_next  = chunk_size_word;
              end
            end else if (hdr_type == gcv_pkg::TYPE_JSON ||
                         (hdr_type == gcv_pkg::TYPE_BIN && chunk_number != 2'd1)) begin
              hdr_fault = 1'b1;
            end else if (hdr_type == gcv_pkg::TYPE_BIN) begin
              saw_binary_chunk_next = 1'b1;
            end
            chunk_fault_next = hdr_fault;
            if (!hdr_fault) begin
              if (chunk_number != 2'd2) begin
                chunk_number_next = chunk_number + 2'd1;
              end
              if (chunk_size_word != 32'd0) begin
                in_payload_next   = 1'b1;
                payload_left_next = chunk_size_word;
              end
            end
          end else begin
            header_byte_index_next = header_byte_index + 3'd1;
          end
        end
      end
      byte_position_next = cursor;
      if (cursor_wide > max_length) begin
        too_long_next = 1'b1;
      end
    end
  end

  assign count_wide = 32'(byte_position_next);

  // Verdict from the state as it stands after the last byte
  always_comb begin
    verdict_status = gcv_pkg::STATUS_OK;
    verdict_binary = 1'b0;
    verdict_offset = 32'd0;
    verdict_length = 32'd0;
    if (too_long_next) begin
      verdict_status = gcv_pkg::STATUS_OVERFLOW;
    end else if (count_wide < 32'(gcv_pkg::MAGIC_BYTES) ||
                 magic_word_next != gcv_pkg::GLB_MAGIC) begin
      verdict_length = count_wide;
    end else if (count_wide < 32'(gcv_pkg::MIN_GLB_SIZE) ||
                 declared_length_next != count_wide) begin
      verdict_status = gcv_pkg::STATUS_INVALID;
    end else if (version_word_next != gcv_pkg::GLB_VERSION) begin
      verdict_status = gcv_pkg::STATUS_VERSION;
    end else if (chunk_fault_next || in_payload_next || header_byte_index_next != 3'd0) begin
      verdict_status = gcv_pkg::STATUS_INVALID;
    end else begin
      verdict_binary = saw_binary_chunk_next;
      verdict_offset = 32'(json_start_next);
      verdict_length = json_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= '1;
    end else if (cfg_write && paddr[2] == gcv_pkg::REG_MAX_LENGTH) begin
      max_length <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_tlast)) begin
      // Drop all file state after the verdict
      byte_position     <= '0;
      too_long          <= 1'b0;
      magic_word        <= '0;
      version_word      <= '0;
      declared_length   <= '0;
      in_payload        <= 1'b0;
      header_byte_index <= '0;
      chunk_size_word   <= '0;
      chunk_type_word   <= '0;
      payload_left      <= '0;
      chunk_number      <= '0;
      saw_binary_chunk  <= 1'b0;
      chunk_fault       <= 1'b0;
      json_start        <= '0;
      json_size         <= '0;
    end else if (in_accept) begin
      byte_position     <= byte_position_next;
      too_long          <= too_long_next;
      magic_word        <= magic_word_next;
      version_word      <= version_word_next;
      declared_length   <= declared_length_next;
      in_payload        <= in_payload_next;
      header_byte_index <= header_byte_index_next;
      chunk_size_word   <= chunk_size_word_next;
      chunk_type_word   <= chunk_type_word_next;
      payload_left      <= payload_left_next;
      chunk_number      <= chunk_number_next;
      saw_binary_chunk  <= saw_binary_chunk_next;
      chunk_fault       <= chunk_fault_next;
      json_start        <= json_start_next;
      json_size         <= json_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      out_status <= verdict_status;
      out_binary <= verdict_binary;
      out_offset <= verdict_offset;
      out_length <= verdict_length;
    end
  end

  assign m_tdata = {5'd0, out_length, out_offset, out_binary, out_status};

  `GCV_ASSERT_IMPL(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !s_tready)
  `GCV_ASSERT_NEXT(a_last_gives_item, clk, rst, in_accept && s_tlast, m_tvalid)
  `GCV_ASSERT_NEXT(a_inner_no_item, clk, rst, in_accept && !s_tlast && m_tready, !m_tvalid)
  `GCV_ASSERT_NEXT(a_restart_after_last, clk, rst, in_accept && s_tlast, byte_position == '0)
  `GCV_ASSERT_IMPL(a_payload_count, clk, rst, in_payload, payload_left != 32'd0)

endmodule

### sim/glb_container_validator_tb.sv
// Self-checking testbench for glb_container_validator: byte stream in, one verdict per file out.
// Depends on gcv_pkg and the glb_container_validator RTL; predicts verdicts on its own.
`timescale 1ns / 100ps

module glb_container_validator_tb;

  localparam int unsigned LEN_BITS      = 32;
  localparam bit [31:0]   COUNT_MAX     = 32'hFFFF_FFFF >> (32 - LEN_BITS);
  localparam bit [31:0]   TYPE_OTHER    = 32'h5845_5400;
  localparam logic [2:0]  ADDR_MAX_LEN  = {gcv_pkg::REG_MAX_LENGTH, 2'b00};
  localparam int          LONG_STALL    = 300;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          PHASE_BYTES   = 240;
  localparam int          PRINT_CAP     = 40;

  typedef struct packed {
    bit [7:0] data;
    bit       last;
    bit       hold;   // wait for all verdicts before offering this item
  } byte_item_t;

  typedef struct {
    gcv_pkg::status_t status;
    bit               is_binary;
    bit [31:0]        offset;
    bit [31:0]        length;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
  logic        s_tlast = 1'b0;    // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;           // [1:0] status, [2] is_binary, [34:3] json_offset,
                                  // [66:35] json_length, [71:67] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  glb_container_validator #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  byte_item_t byte_q[$];
  verdict_t   verdict_q[$];
  bit [7:0]   file_buf[$];
  int         queued_count = 0;
  int         sent_count = 0;
  int         results_seen = 0;
  int         fail_count = 0;

  // Predictor state for the file in progress
  bit [31:0] cfg_max_len = 32'hFFFF_FFFF;
  bit [31:0] f_pos, f_magic, f_version, f_declared;
  bit [31:0] f_csize, f_ctype, f_left, f_json_start, f_json_size;
  bit        f_too_long, f_in_payload, f_bin, f_fault;
  bit [2:0]  f_hdr_idx;
  bit [1:0]  f_chunk_no;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("[%0t] verdict %0d %s: got %0h want %0h", $time, results_seen, what, got, want);
  endtask

  function automatic int pick_gap(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Advance the file state by one accepted byte; queue a verdict on the last one.
  task automatic take_byte(input bit [7:0] b, input bit last);
    bit [31:0] room;
    bit [31:0] cursor;
    verdict_t  v;
    if (f_pos >= COUNT_MAX) begin
      f_too_long = 1'b1;
    end else begin
      if (f_pos < gcv_pkg::MAGIC_BYTES) begin
        f_magic = {b, f_magic[31:8]};
      end else if (f_pos < gcv_pkg::VERSION_END) begin
        f_version = {b, f_version[31:8]};
      end else if (f_pos < gcv_pkg::FILE_HEADER_BYTES) begin
        f_declared = {b, f_declared[31:8]};
      end else if (!f_fault) begin
        if (f_in_payload) begin
          f_left--;
          if (f_left == 0) f_in_payload = 1'b0;
        end else begin
          if (f_hdr_idx < 4) f_csize = {b, f_csize[31:8]};
          else f_ctype = {b, f_ctype[31:8]};
          if (f_hdr_idx >= gcv_pkg::CHUNK_HEADER_BYTES - 1) begin
            f_hdr_idx = 0;
            cursor = f_pos + 1;
            room = (f_declared > cursor) ? f_declared - cursor : 32'd0;
            if (f_csize[1:0] != 2'd0 || f_csize > room) begin
              f_fault = 1'b1;
            end else if (f_chunk_no == 0) begin
              if (f_ctype != gcv_pkg::TYPE_JSON || f_csize == 0) begin
                f_fault = 1'b1;
              end else begin
                f_json_start = cursor;
                f_json_size = f_csize;
              end
            end else if (f_ctype == gcv_pkg::TYPE_JSON ||
                         (f_ctype == gcv_pkg::TYPE_BIN && f_chunk_no != 1)) begin
              f_fault = 1'b1;
            end else if (f_ctype == gcv_pkg::TYPE_BIN) begin
              f_bin = 1'b1;
            end
            if (!f_fault) begin
              if (f_chunk_no < 2) f_chunk_no++;
              if (f_csize != 0) begin
                f_in_payload = 1'b1;
                f_left = f_csize;
              end
            end
          end else begin
            f_hdr_idx++;
          end
        end
      end
      f_pos++;
      if (f_pos > cfg_max_len) f_too_long = 1'b1;
    end
    if (last) begin
      v = '{gcv_pkg::STATUS_OK, 1'b0, 32'd0, 32'd0};
      if (f_too_long) begin
        v.status = gcv_pkg::STATUS_OVERFLOW;
      end else if (f_pos < gcv_pkg::MAGIC_BYTES || f_magic != gcv_pkg::GLB_MAGIC) begin
        v.length = f_pos;
      end else if (f_pos < gcv_pkg::MIN_GLB_SIZE || f_declared != f_pos) begin
        v.status = gcv_pkg::STATUS_INVALID;
      end else if (f_version != gcv_pkg::GLB_VERSION) begin
        v.status = gcv_pkg::STATUS_VERSION;
      end else if (f_fault || f_in_payload || f_hdr_idx != 0) begin
        v.status = gcv_pkg::STATUS_INVALID;
      end else begin
        v.is_binary = f_bin;
        v.offset = f_json_start;
        v.length = f_json_size;
      end
      verdict_q.push_back(v);
      // start over for the next file
      f_pos = 0; f_too_long = 0; f_magic = 0; f_version = 0; f_declared = 0;
      f_in_payload = 0; f_hdr_idx = 0; f_csize = 0; f_ctype = 0; f_left = 0;
      f_chunk_no = 0; f_bin = 0; f_fault = 0; f_json_start = 0; f_json_size = 0;
    end
  endtask

  // Byte stream driver
  int         tx_wait = 0;
  bit         tx_quiet = 1'b0;
  byte_item_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_byte(s_tdata, s_tlast);
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0 && !(byte_q[0].hold && verdict_q.size() > 0)) begin
          next_byte = byte_q.pop_front();
          s_tdata <= next_byte.data;
          s_tlast <= next_byte.last;
          s_tvalid <= 1'b1;
          tx_wait = pick_gap(tx_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor
  int       rx_wait = 0;
  bit       rx_quiet = 1'b0;
  verdict_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected, status", m_tdata[1:0], 32'd0);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", m_tdata[1:0], want.status);
          if (m_tdata[2] !== want.is_binary)
            report_mismatch("is_binary", m_tdata[2], want.is_binary);
          if (m_tdata[34:3] !== want.offset)
            report_mismatch("json_offset", m_tdata[34:3], want.offset);
          if (m_tdata[66:35] !== want.length)
            report_mismatch("json_length", m_tdata[66:35], want.length);
          if (m_tdata[71:67] !== 5'd0)
            report_mismatch("padding", m_tdata[71:67], 32'd0);
        end
        results_seen++;
        // long hold-off lets the block back up onto its input
        if (results_seen == 10 || results_seen == 60) rx_wait = LONG_STALL;
        else rx_wait = pick_gap(rx_quiet);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_max_length(input bit [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_MAX_LEN; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_max_len = value;
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) report_mismatch("max_length readback", prdata, value);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (sent_count != queued_count || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_u32(input bit [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.push_back(w[8*i +: 8]);
  endtask

  task automatic put_random(input int count);
    for (int i = 0; i < count; i++) file_buf.push_back(8'($urandom));
  endtask

  task automatic open_glb(input bit [31:0] version);
    file_buf.delete();
    put_u32(gcv_pkg::GLB_MAGIC);
    put_u32(version);
    put_u32(32'd0);
  endtask

  task automatic put_chunk(input bit [31:0] size, input bit [31:0] ctype, input int body);
    put_u32(size);
    put_u32(ctype);
    put_random(body);
  endtask

  task automatic set_declared(input bit [31:0] len);
    for (int i = 0; i < 4; i++) file_buf[gcv_pkg::FILE_HEADER_BYTES - 4 + i] = len[8*i +: 8];
  endtask

  task automatic send_file(input bit hold);
    byte_item_t it;
    for (int i = 0; i < file_buf.size(); i++) begin
      it.data = file_buf[i];
      it.last = (i == file_buf.size() - 1);
      it.hold = hold && (i == 0);
      byte_q.push_back(it);
    end
    queued_count += file_buf.size();
  endtask

  task automatic close_glb(input int adj);
    set_declared(file_buf.size() + adj);
    send_file(1'b0);
  endtask

  initial begin
    bit [31:0] phase_cfg[4];
    int        start;
    int        json_n;
    int        idx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_max_length(32'hFFFF_FFFF);
    // plain JSON (shorter than the magic, byte extremes, near-miss magic), then the magic alone
    file_buf = {8'h7B}; send_file(1'b0);
    file_buf = {8'h00, 8'hFF, 8'h80}; send_file(1'b0);
    file_buf.delete(); put_u32(gcv_pkg::GLB_MAGIC ^ 32'h0100_0000); put_random(16);
    send_file(1'b0);
    file_buf.delete(); put_u32(gcv_pkg::GLB_MAGIC); send_file(1'b0);
    // well-formed containers
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(8, gcv_pkg::TYPE_JSON, 8); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4);
    put_chunk(8, gcv_pkg::TYPE_BIN, 8); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4);
    put_chunk(0, gcv_pkg::TYPE_BIN, 0);
    put_chunk(4, TYPE_OTHER, 4); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4);
    put_chunk(0, TYPE_OTHER, 0); close_glb(0);
    // chunk faults: late binary, second JSON, binary first, empty JSON
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4);
    put_chunk(4, TYPE_OTHER, 4);
    put_chunk(4, gcv_pkg::TYPE_BIN, 4); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4);
    put_chunk(4, gcv_pkg::TYPE_JSON, 4); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_BIN, 4); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(0, gcv_pkg::TYPE_JSON, 0); close_glb(0);
    // size not a multiple of four, size past the end, partial header, open payload
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(6, gcv_pkg::TYPE_JSON, 8); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(16, gcv_pkg::TYPE_JSON, 8); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4); put_random(4);
    close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(12, gcv_pkg::TYPE_JSON, 4); close_glb(8);
    // header checks and their order
    open_glb(gcv_pkg::GLB_VERSION); close_glb(0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4); close_glb(-4);
    open_glb(32'd1); put_chunk(4, gcv_pkg::TYPE_JSON, 4); close_glb(0);
    open_glb(32'hFFFF_FFFF); put_chunk(4, gcv_pkg::TYPE_BIN, 4); close_glb(0);
    open_glb(32'd1); put_chunk(4, gcv_pkg::TYPE_JSON, 4); close_glb(4);
    settle();

    // smallest limit: only a single byte gets through
    write_max_length(32'd1);
    file_buf = {8'hFF}; send_file(1'b0);
    file_buf = {8'h00, 8'h00}; send_file(1'b0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(4, gcv_pkg::TYPE_JSON, 4); close_glb(0);
    settle();

    // limit right at the file size and one past it
    write_max_length(32'd40);
    file_buf.delete(); put_random(40); send_file(1'b0);
    file_buf.delete(); put_random(41); send_file(1'b0);
    open_glb(gcv_pkg::GLB_VERSION); put_chunk(20, gcv_pkg::TYPE_JSON, 20); close_glb(0);
    open_glb(32'd3); put_chunk(24, gcv_pkg::TYPE_JSON, 24); close_glb(0);
    settle();

    phase_cfg[0] = $urandom_range(28, 72);
    phase_cfg[1] = 32'hFFFF_FFFF;
    phase_cfg[2] = $urandom_range(40, 100);
    phase_cfg[3] = 32'hFFFF_FFFF;
    for (int p = 0; p < 4; p++) begin
      write_max_length(phase_cfg[p]);
      start = queued_count;
      while (queued_count - start < PHASE_BYTES) begin
        open_glb(gcv_pkg::GLB_VERSION);
        json_n = 4 * $urandom_range(1, 6);
        put_chunk(json_n, gcv_pkg::TYPE_JSON, json_n);
        if ($urandom_range(0, 2) != 0) begin
          json_n = 4 * $urandom_range(0, 4);
          put_chunk(json_n, gcv_pkg::TYPE_BIN, json_n);
        end
        if ($urandom_range(0, 3) == 0) begin
          json_n = 4 * $urandom_range(0, 3);
          case ($urandom_range(0, 5))
            0: put_chunk(json_n, gcv_pkg::TYPE_JSON, json_n);
            1: put_chunk(json_n, gcv_pkg::TYPE_BIN, json_n);
            default: put_chunk(json_n, $urandom, json_n);
          endcase
        end
        set_declared(file_buf.size());
        // break roughly a third of the files
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0: begin
              idx = $urandom_range(0, (file_buf.size() < 32) ? file_buf.size() - 1 : 31);
              file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            1: repeat ($urandom_range(1, 8)) if (file_buf.size() > 1) void'(file_buf.pop_back());
            2: begin
              repeat ($urandom_range(1, 8)) void'(file_buf.pop_back());
              set_declared(file_buf.size());
            end
            3: put_random($urandom_range(1, 8));
            4: file_buf[gcv_pkg::VERSION_END - 1 - $urandom_range(0, 3)] = 8'($urandom);
            default: begin
              file_buf.delete();
              put_random($urandom_range(1, 40));
            end
          endcase
        end
        send_file($urandom_range(0, 7) == 0);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
